### hw/rtl/drs_pkg.sv
// Package with constants and helpers for the decimal radix sorter.
package drs_pkg;
    localparam int MaxItemsDefault  = 64;
    localparam int ValueBitsDefault = 31;
    localparam int DigitBase        = 10;
    localparam int DigitBits        = 4;

    // Sorter control states, one-hot.
    typedef enum logic [7:0] {
        ST_LOAD   = 8'b0000_0001,
        ST_START  = 8'b0000_0010,
        ST_COUNT  = 8'b0000_0100,
        ST_PREFIX = 8'b0000_1000,
        ST_SCAT   = 8'b0001_0000,
        ST_COPY   = 8'b0010_0000,
        ST_EMIT   = 8'b0100_0000,
        ST_NEXT   = 8'b1000_0000
    } state_t;

    // Powers of ten up to the first one above any 31-bit value.
    function automatic logic [35:0] pow_ten(input logic [3:0] power);
        logic [35:0] result;
        case (power)
            4'd0:    result = 36'd1;
            4'd1:    result = 36'd10;
            4'd2:    result = 36'd100;
            4'd3:    result = 36'd1000;
            4'd4:    result = 36'd10000;
            4'd5:    result = 36'd100000;
            4'd6:    result = 36'd1000000;
            4'd7:    result = 36'd10000000;
            4'd8:    result = 36'd100000000;
            4'd9:    result = 36'd1000000000;
            4'd10:   result = 36'd10000000000;
            default: result = 36'hF_FFFF_FFFF;
        endcase
        return result;
    endfunction
endpackage

### hw/rtl/decimal_radix_sorter.sv
// Top level of the decimal radix sorter: store, counting passes and output.
// Loading takes one transaction per cycle; after the closing one, a start state, then for each
// needed digit pass count, prefix, scatter, copy and next states, with digits from the digit unit.
// Throughput: one set at a time; results leave one at a time while m_tready is high.
// Reset (asynchronous, active low) clears control state and bucket counts;
// the value and scratch memories hold undefined data until written.
module decimal_radix_sorter
    import drs_pkg::*;
#(
    parameter int MAX_ITEMS  = MaxItemsDefault,
    parameter int VALUE_BITS = ValueBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value
    input  logic        s_tlast,   // last_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] sorted_value
    output logic        m_tlast,   // last_result
    output logic        m_tuser    // overflow
);
    localparam int AddrBits = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CntBits  = $clog2(MAX_ITEMS + 1);

    logic [VALUE_BITS-1:0] value_mem   [MAX_ITEMS];
    logic [VALUE_BITS-1:0] scratch_mem [MAX_ITEMS];
    logic [CntBits-1:0]    bucket_reg  [DigitBase];

    state_t                state_reg;
    logic [CntBits-1:0]    count_reg;
    logic [VALUE_BITS-1:0] max_reg;
    logic                  drop_reg;
    logic [3:0]            pass_reg;
    logic [CntBits-1:0]    idx_reg;
    logic [3:0]            dig_idx_reg;
    logic [1:0]            phase_reg;
    logic [VALUE_BITS-1:0] vrd_reg;
    logic [VALUE_BITS-1:0] srd_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_data_reg;
    logic                  out_last_reg;
    logic                  out_ovf_reg;

    logic                  dig_start;
    logic                  dig_done;
    logic [DigitBits-1:0]  dig;
    logic [VALUE_BITS-1:0] in_value;
    logic                  accept;
    logic                  out_free;
    logic [AddrBits-1:0]   cur_addr;
    logic [CntBits-1:0]    slot;

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign cur_addr = AddrBits'(idx_reg);
    assign slot     = bucket_reg[dig] - 1'b1;

    assign dig_start = (state_reg == ST_COUNT || state_reg == ST_SCAT) && phase_reg == 2'd1;

    drs_digit #(.VALUE_BITS(VALUE_BITS)) u_digit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dig_start),
        .value      (vrd_reg),
        .pass_index (pass_reg),
        .done       (dig_done),
        .digit      (dig)
    );

    // Memory ports: value memory read by address, written at load and copy.
    always_ff @(posedge clk)
    begin
        vrd_reg <= value_mem[cur_addr];
        srd_reg <= scratch_mem[cur_addr];
        if (accept && count_reg < CntBits'(MAX_ITEMS))
            value_mem[AddrBits'(count_reg)] <= in_value;
        else if (state_reg == ST_COPY && phase_reg == 2'd1)
            value_mem[cur_addr] <= srd_reg;
        if (state_reg == ST_SCAT && dig_done)
            scratch_mem[AddrBits'(slot)] <= vrd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            max_reg       <= '0;
            drop_reg      <= 1'b0;
            pass_reg      <= '0;
            idx_reg       <= '0;
            dig_idx_reg   <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < DigitBase; b++)
                bucket_reg[b] <= '0;
        end
        else
        begin
            // The emit step below loads the next result in the same cycle.
            if (out_valid_reg && m_tready && !(state_reg == ST_EMIT && phase_reg == 2'd1))
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_LOAD:
                begin
                    if (accept)
                    begin
                        if (count_reg < CntBits'(MAX_ITEMS))
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (in_value > max_reg)
                                max_reg <= in_value;
                        end
                        else
                            drop_reg <= 1'b1;
                        if (s_tlast)
                            state_reg <= ST_START;
                    end
                end
                ST_START:
                begin
                    // Passes run while max / weight is nonzero.
                    pass_reg    <= '0;
                    idx_reg     <= '0;
                    phase_reg   <= '0;
                    for (int b = 0; b < DigitBase; b++)
                        bucket_reg[b] <= '0;
                    state_reg <= (max_reg == '0) ? ST_EMIT : ST_COUNT;
                end
                ST_COUNT:
                begin
                    if (idx_reg == count_reg)
                    begin
                        dig_idx_reg <= 4'd1;
                        state_reg   <= ST_PREFIX;
                    end
                    else if (phase_reg == 2'd0)
                        phase_reg <= 2'd1;        // memory read in flight
                    else if (phase_reg == 2'd1)
                        phase_reg <= 2'd2;        // digit unit started
                    else if (dig_done)
                    begin
                        bucket_reg[dig] <= bucket_reg[dig] + 1'b1;
                        idx_reg   <= idx_reg + 1'b1;
                        phase_reg <= 2'd0;
                    end
                end
                ST_PREFIX:
                begin
                    bucket_reg[dig_idx_reg] <= bucket_reg[dig_idx_reg]
                        + bucket_reg[dig_idx_reg - 1'b1];
                    if (dig_idx_reg == 4'(DigitBase - 1))
                    begin
                        idx_reg   <= count_reg - 1'b1;
                        phase_reg <= 2'd0;
                        state_reg <= ST_SCAT;
                    end
                    else
                        dig_idx_reg <= dig_idx_reg + 1'b1;
                end
                ST_SCAT:
                begin
                    if (phase_reg == 2'd0)
                        phase_reg <= 2'd1;
                    else if (phase_reg == 2'd1)
                        phase_reg <= 2'd2;
                    else if (dig_done)
                    begin
                        bucket_reg[dig] <= slot;
                        phase_reg <= 2'd0;
                        if (idx_reg == '0)
                            state_reg <= ST_COPY;
                        else
                            idx_reg <= idx_reg - 1'b1;
                    end
                end
                ST_COPY:
                begin
                    if (idx_reg == count_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_NEXT;
                    end
                    else if (phase_reg == 2'd0)
                        phase_reg <= 2'd1;
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        phase_reg <= 2'd0;
                    end
                end
                ST_NEXT:
                begin
                    // Another pass is needed while max >= 10^(pass+1).
                    for (int b = 0; b < DigitBase; b++)
                        bucket_reg[b] <= '0;
                    idx_reg   <= '0;
                    phase_reg <= '0;
                    if (36'(max_reg) < pow_ten(pass_reg + 1'b1))
                        state_reg <= ST_EMIT;
                    else
                    begin
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= ST_COUNT;
                    end
                end
                ST_EMIT:
                begin
                    if (phase_reg == 2'd0)
                        phase_reg <= 2'd1;
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= vrd_reg;
                        out_last_reg  <= (idx_reg + 1'b1 == count_reg);
                        out_ovf_reg   <= drop_reg;
                        phase_reg     <= 2'd0;
                        if (idx_reg + 1'b1 == count_reg)
                        begin
                            count_reg <= '0;
                            max_reg   <= '0;
                            drop_reg  <= 1'b0;
                            idx_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                    state_reg <= ST_LOAD;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 32'(out_data_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;
endmodule

### hw/rtl/drs_digit.sv
// Extracts one decimal digit from a value divided by a power-of-ten weight.
module drs_digit
    import drs_pkg::*;
#(
    parameter int VALUE_BITS = ValueBitsDefault
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [3:0]            pass_index,
    output logic                  done,
    output logic [DigitBits-1:0]  digit
);
    // Each division by ten is a reciprocal multiplication:
    // the quotient is registered, then either fed back or used for the remainder.
    localparam logic [63:0] RecipTen   = 64'h0000_0000_CCCC_CCCD;
    localparam int          RecipShift = 35;

    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [DigitBits-1:0]  rem_reg, rem_next;
    logic [3:0]            div_reg, div_next;
    logic                  step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [31:0]           rem_wide;

    assign rem_wide = 32'(num_reg) - ((32'(quo_reg) << 3) + (32'(quo_reg) << 1));

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = value;
            div_next  = pass_index;
            step_next = 1'b0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!step_reg)
            begin
                quo_next  = VALUE_BITS'((64'(num_reg) * RecipTen) >> RecipShift);
                step_next = 1'b1;
            end
            else if (div_reg != '0)
            begin
                // One division by ten done; strip another digit.
                num_next  = quo_reg;
                div_next  = div_reg - 1'b1;
                step_next = 1'b0;
            end
            else
            begin
                rem_next  = rem_wide[DigitBits-1:0];
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        step_reg <= step_next;
    end

    assign done  = done_reg;
    assign digit = rem_reg;
endmodule

### hw/rtl/drs_checker.sv
// Port-level checker for the decimal radix sorter, with its bind.
module drs_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast
);
    // No new input is taken while a sorted run is leaving.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> ##1 !(s_tvalid && s_tready) || m_tvalid)
        else $error("input taken during output run");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    a_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31] == 1'b0)
        else $error("padding bit set");

    a_reset_out: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid || !$past(rst_n) == 1'b0)
        else $error("output valid after reset");
endmodule

bind decimal_radix_sorter drs_checker u_drs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/sv/decimal_radix_sorter_checker.sv
// Checker for the decimal radix sorter: predicts sorted runs and compares output transactions.
module decimal_radix_sorter_checker
    import drs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic        m_tuser,
    output int          errors,
    output int          pending
);
    typedef struct packed {
        logic [30:0] sorted_value;
        logic        last_result;
        logic        overflow;
    } sorted_item_t;

    logic [30:0]  set_values[$];
    logic         set_dropped;
    sorted_item_t sorted_queue[$];

    // Stable order does not matter here: equal keys are indistinguishable values.
    task automatic close_set();
        sorted_item_t item;
        set_values.sort();
        foreach (set_values[i])
        begin
            item.sorted_value = set_values[i];
            item.last_result  = (i == set_values.size() - 1);
            item.overflow     = set_dropped;
            sorted_queue.push_back(item);
        end
        set_values.delete();
        set_dropped = 1'b0;
    endtask

    always @(posedge clk)
    begin
        sorted_item_t want;
        if (!rst_n)
        begin
            set_values.delete();
            sorted_queue.delete();
            set_dropped = 1'b0;
            errors      = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (set_values.size() < MaxItemsDefault)
                    set_values.push_back(s_tdata[30:0]);
                else
                    set_dropped = 1'b1;
                if (s_tlast)
                    close_set();
            end
            if (m_tvalid && m_tready)
            begin
                if (sorted_queue.size() == 0)
                begin
                    $error("unexpected output transaction: sorted_value %0d", m_tdata[30:0]);
                    errors++;
                end
                else
                begin
                    want = sorted_queue.pop_front();
                    if (m_tdata[30:0] !== want.sorted_value)
                    begin
                        $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                               m_tdata[30:0]);
                        errors++;
                    end
                    if (m_tlast !== want.last_result)
                    begin
                        $error("last_result: expected %0b, got %0b", want.last_result,
                               m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.overflow)
                    begin
                        $error("overflow: expected %0b, got %0b", want.overflow, m_tuser);
                        errors++;
                    end
                end
            end
        end
        pending = sorted_queue.size();
    end
endmodule

### tb/sv/decimal_radix_sorter_tb.sv
// Testbench top for the decimal radix sorter: clock, reset, stimulus and verdict.
module decimal_radix_sorter_tb;
    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    int          errors;
    int          pending;
    bit          gaps_on;
    int          items_sent;
    int          stall_left = 0;

    decimal_radix_sorter u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    decimal_radix_sorter_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Output side stalls in bursts while gaps are enabled.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 11);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_value(input logic [30:0] value, input logic closing);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, value};
        s_tlast  <= closing;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    function automatic logic [30:0] random_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 5)
            return 31'($urandom_range(0, 999));
        else if (pick <= 7)
            return 31'($urandom_range(0, 99999));
        else if (pick == 8)
            return 31'($urandom());
        else
            return 31'd0;
    endfunction

    task automatic send_random_set(input int count);
        logic [30:0] recent;
        recent = random_value();
        for (int i = 0; i < count; i++)
        begin
            // Repeat an earlier value now and then so that equal keys are sorted.
            if ($urandom_range(0, 3) != 0)
                recent = random_value();
            send_value(recent, i == count - 1);
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        gaps_on    = 1'b1;
        items_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single zero: no digit pass at all.
        send_value(31'd0, 1'b1);
        // Single largest value.
        send_value(31'h7FFF_FFFF, 1'b1);
        // Set in nearly descending order with the extremes and repeated keys.
        send_value(31'h7FFF_FFFF, 1'b0);
        send_value(31'd1000000000, 1'b0);
        send_value(31'h5555_5555, 1'b0);
        send_value(31'h2AAA_AAAA, 1'b0);
        send_value(31'd10, 1'b0);
        send_value(31'd10, 1'b0);
        send_value(31'd9, 1'b0);
        send_value(31'd0, 1'b1);
        // All zeros.
        send_value(31'd0, 1'b0);
        send_value(31'd0, 1'b0);
        send_value(31'd0, 1'b1);
        // Full store plus dropped items; the closing one is dropped too.
        for (int i = 0; i < 67; i++)
            send_value(31'($urandom_range(0, 99)), i == 66);

        while (items_sent < 450)
        begin
            if (items_sent >= 390)
                gaps_on = 1'b0;
            if ($urandom_range(0, 39) == 0)
                send_random_set($urandom_range(60, 70));
            else
                send_random_set($urandom_range(1, 8));
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
